// ===== rtl/framed_decimal_field_parser_unit_macros.svh =====
// assertion macros used by the checker file
`ifndef FRAMED_DECIMAL_FIELD_PARSER_UNIT_MACROS_SVH
`define FRAMED_DECIMAL_FIELD_PARSER_UNIT_MACROS_SVH

// checked on every clock edge outside reset
`define FDP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define FDP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/fdp_pkg.sv =====
// types and constants of the framed decimal field parser
package fdp_pkg;

    typedef enum logic [1:0] {
        PH_WS   = 2'd0,
        PH_NUM  = 2'd1,
        PH_DONE = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        CFG_START = 2'd0,
        CFG_SEP   = 2'd1,
        CFG_END   = 2'd2
    } cfg_idx_t;

    localparam logic [31:0] MAG_LIMIT  = 32'h8000_0000;
    localparam logic [31:0] POS_MAX    = 32'h7FFF_FFFF;
    localparam logic [31:0] MINUS_ONE  = 32'hFFFF_FFFF;
    localparam logic [5:0]  OVER_INDEX = 6'd63;

    localparam logic [7:0] START_RESET = 8'd42;
    localparam logic [7:0] SEP_RESET   = 8'd44;
    localparam logic [7:0] END_RESET   = 8'd10;

    typedef struct packed {
        phase_t      phase;
        logic        neg;
        logic [31:0] acc;
    } decode_t;

    typedef struct packed {
        logic [7:0] start_char;
        logic [7:0] separator_char;
        logic [7:0] end_char;
    } cfg_t;

endpackage

// ===== rtl/fdp_byte_if.sv =====
// received byte channel
interface fdp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/fdp_field_if.sv =====
// decoded field channel
interface fdp_field_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] field_value;
    logic [5:0]         field_number;
    logic               last_field;
    logic               packet_accepted;
    logic               index_overflow;

    modport source (output valid, output field_value, output field_number,
                    output last_field, output packet_accepted, output index_overflow,
                    input ready);
    modport sink (input valid, input field_value, input field_number,
                  input last_field, input packet_accepted, input index_overflow,
                  output ready);
endinterface

// ===== rtl/fdp_atoi.sv =====
// one atoi step: next decode state from the current one and a data byte
module fdp_atoi
    import fdp_pkg::*;
(
    input  decode_t    cur,
    input  logic [7:0] data,
    output decode_t    nxt
);

    logic        digit;
    logic        space;
    logic [3:0]  dval;
    logic [35:0] prod;

    always_comb
    begin
        digit = (data inside {[8'd48:8'd57]});
        space = (data inside {8'd32, [8'd9:8'd13]});
        dval  = 4'(data - 8'd48);
        // acc * 10 + digit, acc never exceeds 2^31 so 36 bits hold it
        prod  = {1'b0, cur.acc, 3'b000} + {3'b000, cur.acc, 1'b0} + {32'd0, dval};
        nxt   = cur;
        case (cur.phase)
            PH_WS:
            begin
                if (space)
                begin
                    nxt = cur;
                end
                else if (data == 8'd43 || data == 8'd45)
                begin
                    nxt.neg   = (data == 8'd45);
                    nxt.phase = PH_NUM;
                end
                else if (digit)
                begin
                    nxt.acc   = {28'd0, dval};
                    nxt.phase = PH_NUM;
                end
                else
                begin
                    nxt.phase = PH_DONE;
                end
            end
            PH_NUM:
            begin
                if (digit)
                begin
                    nxt.acc = (prod > {4'd0, MAG_LIMIT}) ? MAG_LIMIT : prod[31:0];
                end
                else
                begin
                    nxt.phase = PH_DONE;
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

// ===== rtl/fdp_core.sv =====
// field state, counters, packet check and result register
module fdp_core
    import fdp_pkg::*;
#(
    parameter int BUF_LEN    = 128,
    parameter int MAX_FIELDS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        item_valid,
    input  logic [7:0]  item_byte,
    output logic        advance,
    fdp_field_if.source fields
);

    localparam int CCW = $clog2(BUF_LEN + 1);
    localparam int FCW = $clog2(MAX_FIELDS + 1);

    decode_t            dec_reg, dec_next, dec_step;
    logic [CCW-1:0]     cnt_reg, cnt_next, cnt_inc;
    logic [FCW-1:0]     fcnt_reg, fcnt_next;
    logic [31:0]        first_reg, first_next;
    logic [31:0]        second_reg, second_next;
    logic               init_reg, init_next;

    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] out_value_reg, out_value_next;
    logic [5:0]         out_num_reg, out_num_next;
    logic               out_last_reg, out_last_next;
    logic               out_acc_reg, out_acc_next;
    logic               out_ovf_reg, out_ovf_next;

    logic               fire, is_start, is_sep, is_end, emit, over;
    logic [31:0]        value;

    decode_t            dec_clear;

    fdp_atoi u_atoi (
        .cur  (dec_reg),
        .data (item_byte),
        .nxt  (dec_step)
    );

    assign advance = !out_valid_reg || fields.ready;
    assign fire    = item_valid && advance;

    always_comb
    begin
        dec_clear = '{phase: PH_WS, neg: 1'b0, acc: 32'd0};
        is_start  = (item_byte == cfg.start_char);
        is_sep    = !is_start && (item_byte == cfg.separator_char);
        is_end    = !is_start && !is_sep && (item_byte == cfg.end_char);
        emit      = is_sep || is_end;
        over      = (fcnt_reg >= FCW'(MAX_FIELDS));
        cnt_inc   = cnt_reg + CCW'(1);
        if (dec_reg.neg)
        begin
            value = 32'd0 - dec_reg.acc;
        end
        else if (dec_reg.acc[31])
        begin
            value = POS_MAX;
        end
        else
        begin
            value = dec_reg.acc;
        end
    end

    // state update for the byte in the input register
    always_comb
    begin
        dec_next    = dec_reg;
        cnt_next    = cnt_reg;
        fcnt_next   = fcnt_reg;
        first_next  = first_reg;
        second_next = second_reg;
        init_next   = init_reg;
        if (fire)
        begin
            if (emit && !over)
            begin
                if (fcnt_reg == FCW'(0))
                begin
                    first_next = value;
                end
                else if (fcnt_reg == FCW'(1))
                begin
                    second_next = value;
                end
            end
            if (is_start)
            begin
                dec_next  = dec_clear;
                cnt_next  = '0;
                fcnt_next = '0;
            end
            else if (is_sep)
            begin
                dec_next = dec_clear;
                cnt_next = '0;
                if (!over)
                begin
                    fcnt_next = fcnt_reg + FCW'(1);
                end
            end
            else if (is_end)
            begin
                if (init_reg && first_next != MINUS_ONE && second_next != MINUS_ONE)
                begin
                    init_next = 1'b0;
                end
            end
            else
            begin
                // long field restarts after BUF_LEN data bytes
                if (cnt_inc >= CCW'(BUF_LEN))
                begin
                    dec_next = dec_clear;
                    cnt_next = '0;
                end
                else
                begin
                    dec_next = dec_step;
                    cnt_next = cnt_inc;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_num_next   = out_num_reg;
        out_last_next  = out_last_reg;
        out_acc_next   = out_acc_reg;
        out_ovf_next   = out_ovf_reg;
        if (advance)
        begin
            out_valid_next = fire && emit;
        end
        if (fire && emit)
        begin
            out_value_next = value;
            out_num_next   = over ? OVER_INDEX : 6'(fcnt_reg);
            out_last_next  = is_end;
            out_acc_next   = is_end && !init_next;
            out_ovf_next   = over;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_reg       <= '{phase: PH_WS, neg: 1'b0, acc: 32'd0};
            cnt_reg       <= '0;
            fcnt_reg      <= '0;
            first_reg     <= MINUS_ONE;
            second_reg    <= MINUS_ONE;
            init_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            dec_reg       <= dec_next;
            cnt_reg       <= cnt_next;
            fcnt_reg      <= fcnt_next;
            first_reg     <= first_next;
            second_reg    <= second_next;
            init_reg      <= init_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        out_num_reg   <= out_num_next;
        out_last_reg  <= out_last_next;
        out_acc_reg   <= out_acc_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign fields.valid           = out_valid_reg;
    assign fields.field_value     = out_value_reg;
    assign fields.field_number    = out_num_reg;
    assign fields.last_field      = out_last_reg;
    assign fields.packet_accepted = out_acc_reg;
    assign fields.index_overflow  = out_ovf_reg;

endmodule

// ===== rtl/framed_decimal_field_parser_unit.sv =====
// Framed decimal field parser: takes one received byte per clock, unless
// stalled, and decodes separator-delimited signed decimal fields with atoi
// rules. A byte is taken into an input register and processed from there into
// the result register, so a field result is registered after the separator or
// end byte has passed through the input register; the sustained rate is one
// byte per cycle when the output does not stall, set by the update of the
// per-field accumulator (multiply by ten, add the digit, saturate). Bytes that
// produce no result (data and start bytes) leave nothing on the output. The
// input stalls only while a finished result is held and not taken.
module framed_decimal_field_parser_unit
    import fdp_pkg::*;
#(
    parameter int BUF_LEN    = 128,
    parameter int MAX_FIELDS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    fdp_byte_if.sink    rx,
    fdp_field_if.source fields
);

    cfg_t       cfg_reg, cfg_next;
    logic       item_valid_reg, item_valid_next;
    logic [7:0] item_byte_reg, item_byte_next;
    logic       advance;
    logic       rx_take;

    assign rx.ready = !item_valid_reg || advance;
    assign rx_take  = rx.valid && rx.ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_START: cfg_next.start_char     = cfg_data;
                CFG_SEP:   cfg_next.separator_char = cfg_data;
                CFG_END:   cfg_next.end_char       = cfg_data;
                default:   cfg_next                = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        item_valid_next = item_valid_reg;
        item_byte_next  = item_byte_reg;
        if (rx_take)
        begin
            item_valid_next = 1'b1;
            item_byte_next  = rx.rx_byte;
        end
        else if (advance)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg        <= '{start_char: START_RESET, separator_char: SEP_RESET,
                                end_char: END_RESET};
            item_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg        <= cfg_next;
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_byte_reg <= item_byte_next;
    end

    fdp_core #(
        .BUF_LEN    (BUF_LEN),
        .MAX_FIELDS (MAX_FIELDS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item_valid_reg),
        .item_byte  (item_byte_reg),
        .advance    (advance),
        .fields     (fields)
    );

endmodule

// ===== rtl/fdp_checker.sv =====
// port-level checks of the parser and their binding to the top level
`include "framed_decimal_field_parser_unit_macros.svh"

module fdp_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       rx_valid,
    input logic       rx_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [5:0] out_number,
    input logic       out_last,
    input logic       out_accepted,
    input logic       out_overflow
);

    // a fresh result comes from an input transaction through the input and result registers
    `FDP_ASSERT(a_result_source, $rose(out_valid) |-> $past(rx_valid && rx_ready, 2), "result without input transaction")

    // only an end byte can report an accepted packet
    `FDP_ASSERT(a_accept_on_end, out_valid && !out_last |-> !out_accepted, "accepted flag on separator result")

    `FDP_ASSERT(a_overflow_index, out_valid && out_overflow |-> out_number == 6'd63, "overflow result with wrong index")

    // input stalls only behind a held result
    `FDP_ASSERT(a_stall_cause, !rx_ready |-> out_valid && !out_ready, "input stalled without output backpressure")

    `FDP_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> !out_valid, "result valid during reset")

endmodule

bind framed_decimal_field_parser_unit fdp_checker u_fdp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rx_valid     (rx.valid),
    .rx_ready     (rx.ready),
    .out_valid    (fields.valid),
    .out_ready    (fields.ready),
    .out_number   (fields.field_number),
    .out_last     (fields.last_field),
    .out_accepted (fields.packet_accepted),
    .out_overflow (fields.index_overflow)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the framed decimal field parser unit
module tb_top;
    import fdp_pkg::*;

    localparam int BUF_LEN      = 128;
    localparam int MAX_FIELDS   = 64;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 4;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    typedef struct packed {
        logic signed [31:0] value;
        logic [5:0]         number;
        logic               last;
        logic               accepted;
        logic               overflow;
    } field_rec_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    cfg_idx_t   cfg_index;
    logic [7:0] cfg_data;

    fdp_byte_if  rx_if ();
    fdp_field_if fld_if ();

    framed_decimal_field_parser_unit #(
        .BUF_LEN    (BUF_LEN),
        .MAX_FIELDS (MAX_FIELDS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx        (rx_if),
        .fields    (fld_if)
    );

    // parser state mirrored by the predictor
    logic [7:0]  start_chr;
    logic [7:0]  sep_chr;
    logic [7:0]  end_chr;
    int          char_cnt;
    phase_t      phase;
    logic        neg;
    logic [31:0] mag;
    int          field_cnt;
    logic [31:0] field0_val;
    logic [31:0] field1_val;
    logic        check_pending;

    field_rec_t  field_expect_q[$];
    logic [7:0]  rx_pending_q[$];

    bit idle_en;
    int fail_cnt  = 0;
    int hold_req  = 0;
    int hold_seen;
    int hold_left;
    int src_gap;
    int snk_gap;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic void restart_field();
        char_cnt = 0;
        phase    = PH_WS;
        neg      = 1'b0;
        mag      = '0;
    endfunction

    function automatic void model_reset();
        start_chr     = START_RESET;
        sep_chr       = SEP_RESET;
        end_chr       = END_RESET;
        restart_field();
        field_cnt     = 0;
        field0_val    = MINUS_ONE;
        field1_val    = MINUS_ONE;
        check_pending = 1'b1;
    endfunction

    function automatic logic [31:0] signed_value();
        if (neg)
            return 32'd0 - mag;
        if (mag > POS_MAX)
            return POS_MAX;
        return mag;
    endfunction

    function automatic void take_data(logic [7:0] c);
        logic [63:0] prod;
        logic        is_digit;
        is_digit = (c >= CH_ZERO && c <= CH_NINE);
        case (phase)
            PH_WS:
            begin
                if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
                    phase = PH_WS;
                else if (c == CH_PLUS || c == CH_MINUS)
                begin
                    neg   = (c == CH_MINUS);
                    phase = PH_NUM;
                end
                else if (is_digit)
                begin
                    mag   = {24'd0, c - CH_ZERO};
                    phase = PH_NUM;
                end
                else
                    phase = PH_DONE;
            end
            PH_NUM:
            begin
                if (is_digit)
                begin
                    prod = {32'd0, mag} * 64'd10 + {56'd0, c - CH_ZERO};
                    mag  = (prod > {32'd0, MAG_LIMIT}) ? MAG_LIMIT : prod[31:0];
                end
                else
                    phase = PH_DONE;
            end
            default:
                phase = PH_DONE;
        endcase
    endfunction

    function automatic field_rec_t close_field(logic last);
        field_rec_t  r;
        logic [31:0] v;
        logic        over;
        v    = signed_value();
        over = (field_cnt >= MAX_FIELDS);
        if (!over)
        begin
            if (field_cnt == 0)
                field0_val = v;
            else if (field_cnt == 1)
                field1_val = v;
        end
        r.value    = v;
        r.number   = over ? OVER_INDEX : field_cnt[5:0];
        r.last     = last;
        r.accepted = 1'b0;
        r.overflow = over;
        return r;
    endfunction

    function automatic void decode_byte(logic [7:0] c);
        field_rec_t r;
        if (c == start_chr)
        begin
            restart_field();
            field_cnt = 0;
        end
        else if (c == sep_chr)
        begin
            r = close_field(1'b0);
            field_expect_q.push_back(r);
            if (field_cnt < MAX_FIELDS)
                field_cnt++;
            restart_field();
        end
        else if (c == end_chr)
        begin
            r = close_field(1'b1);
            if (check_pending && field0_val != MINUS_ONE && field1_val != MINUS_ONE)
                check_pending = 1'b0;
            r.accepted = !check_pending;
            field_expect_q.push_back(r);
        end
        else
        begin
            take_data(c);
            char_cnt++;
            if (char_cnt >= BUF_LEN)
                restart_field();
        end
    endfunction

    // stimulus builders

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            rx_pending_q.push_back(s[i]);
    endfunction

    function automatic logic [7:0] pick_digit();
        return 8'($urandom_range(CH_ZERO, CH_NINE));
    endfunction

    function automatic logic [7:0] pick_space();
        logic [7:0] c;
        c = 8'($urandom_range(8, 13));
        return (c == 8'd8) ? CH_SPACE : c;
    endfunction

    function automatic void push_field_body();
        int n;
        case ($urandom_range(0, 11))
            0: ;
            1: rx_pending_q.push_back(8'($urandom_range(65, 122)));
            2: push_text("-1");
            3:
            begin
                // wide magnitudes that can hit saturation
                if ($urandom_range(0, 1))
                    rx_pending_q.push_back(CH_MINUS);
                n = $urandom_range(10, 12);
                repeat (n) rx_pending_q.push_back(pick_digit());
            end
            4:
            begin
                n = $urandom_range(1, 4);
                repeat (n) rx_pending_q.push_back(8'($urandom_range(0, 255)));
            end
            default:
            begin
                n = $urandom_range(0, 2);
                repeat (n) rx_pending_q.push_back(pick_space());
                case ($urandom_range(0, 3))
                    0: rx_pending_q.push_back(CH_MINUS);
                    1: rx_pending_q.push_back(CH_PLUS);
                    default: ;
                endcase
                n = $urandom_range(1, 9);
                repeat (n) rx_pending_q.push_back(pick_digit());
                if ($urandom_range(0, 4) == 0)
                begin
                    rx_pending_q.push_back(($urandom_range(0, 1)) ? CH_SPACE : 8'd120);
                    rx_pending_q.push_back(pick_digit());
                end
            end
        endcase
    endfunction

    function automatic void push_packet(int nfields);
        int n;
        if ($urandom_range(0, 9) != 0)
            rx_pending_q.push_back(start_chr);
        for (int f = 0; f < nfields; f++)
        begin
            push_field_body();
            rx_pending_q.push_back((f == nfields - 1) ? end_chr : sep_chr);
        end
        // trailing bytes keep extending the last field
        if ($urandom_range(0, 7) == 0)
        begin
            rx_pending_q.push_back(pick_digit());
            rx_pending_q.push_back(($urandom_range(0, 1)) ? end_chr : sep_chr);
        end
        if ($urandom_range(0, 9) == 0)
        begin
            n = $urandom_range(1, 3);
            repeat (n) rx_pending_q.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic void push_traffic(int count);
        int goal;
        goal = rx_pending_q.size() + count;
        while (rx_pending_q.size() < goal)
            push_packet($urandom_range(1, 6));
    endfunction

    function automatic void push_overflow_packet();
        rx_pending_q.push_back(start_chr);
        repeat (MAX_FIELDS + 3)
        begin
            rx_pending_q.push_back(pick_digit());
            rx_pending_q.push_back(sep_chr);
        end
        rx_pending_q.push_back(pick_digit());
        rx_pending_q.push_back(end_chr);
    endfunction

    function automatic void push_long_field();
        rx_pending_q.push_back(start_chr);
        repeat (BUF_LEN + 7) rx_pending_q.push_back(pick_digit());
        rx_pending_q.push_back(sep_chr);
        repeat (BUF_LEN + 2) rx_pending_q.push_back(pick_space());
        rx_pending_q.push_back(pick_digit());
        rx_pending_q.push_back(end_chr);
    endfunction

    task automatic write_reg(cfg_idx_t idx, logic [7:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_START: start_chr = val;
            CFG_SEP:   sep_chr   = val;
            CFG_END:   end_chr   = val;
            default: ;
        endcase
    endtask

    task automatic set_chars(logic [7:0] s, logic [7:0] p, logic [7:0] e);
        write_reg(CFG_START, s);
        write_reg(CFG_SEP, p);
        write_reg(CFG_END, e);
        @(negedge clk);
    endtask

    task automatic wait_drain();
        @(negedge clk);
        while (rx_pending_q.size() != 0 || rx_if.valid || field_expect_q.size() != 0)
            @(negedge clk);
        // data and start bytes leave no result but may still be in flight
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // byte driver
    always @(posedge clk or negedge rst_n)
    begin
        logic       nxt_valid;
        logic [7:0] nxt_byte;
        if (!rst_n)
        begin
            rx_if.valid   <= 1'b0;
            rx_if.rx_byte <= '0;
            src_gap = 0;
        end
        else
        begin
            nxt_valid = rx_if.valid;
            nxt_byte  = rx_if.rx_byte;
            if (rx_if.valid && rx_if.ready)
            begin
                decode_byte(rx_if.rx_byte);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid)
            begin
                if (src_gap > 0)
                    src_gap--;
                else if (rx_pending_q.size() > 0)
                begin
                    if (idle_en && $urandom_range(0, 7) == 0)
                        src_gap = $urandom_range(0, 2);
                    else
                    begin
                        nxt_valid = 1'b1;
                        nxt_byte  = rx_pending_q.pop_front();
                    end
                end
            end
            rx_if.valid   <= nxt_valid;
            rx_if.rx_byte <= nxt_byte;
        end
    end

    // result monitor and ready control
    always @(posedge clk or negedge rst_n)
    begin
        field_rec_t want;
        logic       nxt_ready;
        if (!rst_n)
        begin
            fld_if.ready <= 1'b0;
            snk_gap   = 0;
            hold_left = 0;
            hold_seen = 0;
        end
        else
        begin
            if (fld_if.valid && fld_if.ready)
            begin
                if (field_expect_q.size() == 0)
                begin
                    $error("unexpected field transaction: field_value %0d, field_number %0d",
                           fld_if.field_value, fld_if.field_number);
                    fail_cnt++;
                end
                else
                begin
                    want = field_expect_q.pop_front();
                    if (fld_if.field_value !== want.value)
                    begin
                        $error("field_value mismatch: expected %0d, got %0d",
                               $signed(want.value), fld_if.field_value);
                        fail_cnt++;
                    end
                    if (fld_if.field_number !== want.number)
                    begin
                        $error("field_number mismatch: expected %0d, got %0d",
                               want.number, fld_if.field_number);
                        fail_cnt++;
                    end
                    if (fld_if.last_field !== want.last)
                    begin
                        $error("last_field mismatch: expected %0b, got %0b",
                               want.last, fld_if.last_field);
                        fail_cnt++;
                    end
                    if (fld_if.packet_accepted !== want.accepted)
                    begin
                        $error("packet_accepted mismatch: expected %0b, got %0b",
                               want.accepted, fld_if.packet_accepted);
                        fail_cnt++;
                    end
                    if (fld_if.index_overflow !== want.overflow)
                    begin
                        $error("index_overflow mismatch: expected %0b, got %0b",
                               want.overflow, fld_if.index_overflow);
                        fail_cnt++;
                    end
                end
            end
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                nxt_ready = 1'b0;
            end
            else if (snk_gap > 0)
            begin
                snk_gap--;
                nxt_ready = 1'b0;
            end
            else if (idle_en && $urandom_range(0, 5) == 0)
            begin
                snk_gap   = $urandom_range(0, 2);
                nxt_ready = 1'b0;
            end
            else
                nxt_ready = 1'b1;
            fld_if.ready <= nxt_ready;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_START;
        cfg_data      = '0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        fld_if.ready  = 1'b0;
        idle_en       = 1'b1;
        model_reset();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: saturation, sign, whitespace, junk, empty field, byte extremes,
        // bytes after the end byte
        push_text("*\t-9999999999,+77x,,z");
        rx_pending_q.push_back(8'h00);
        rx_pending_q.push_back(8'hFF);
        push_text("\n3\n");
        wait_drain();

        push_traffic(110);
        push_overflow_packet();
        wait_drain();

        // output held off long enough to back up the input
        hold_req++;
        push_traffic(70);
        wait_drain();

        set_chars(8'h00, 8'hFF, 8'h80);
        push_traffic(80);
        push_long_field();
        wait_drain();

        set_chars(8'hFF, 8'h00, CH_CR);
        push_traffic(70);
        wait_drain();

        // separator and end share a byte, separator wins
        set_chars(8'd36, 8'd59, 8'd59);
        push_traffic(70);
        wait_drain();

        // all equal, start wins and nothing is emitted
        set_chars(SEP_RESET, SEP_RESET, SEP_RESET);
        repeat (30) rx_pending_q.push_back(8'($urandom_range(0, 255)));
        wait_drain();

        set_chars(START_RESET, SEP_RESET, END_RESET);
        idle_en = 1'b0;
        push_traffic(120);
        wait_drain();
        repeat (8) @(posedge clk);

        if (fail_cnt == 0 && field_expect_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/fdp_pkg.sv
rtl/fdp_byte_if.sv
rtl/fdp_field_if.sv
rtl/fdp_atoi.sv
rtl/fdp_core.sv
rtl/framed_decimal_field_parser_unit.sv
rtl/fdp_checker.sv
dv/tb_top.sv
